@@ hdl/rfpa_pkg.sv @@
package rfpa_pkg;

  // Field widths of the item, result and register channels
  localparam int MODE_W    = 2;
  localparam int COORD_W   = 8;
  localparam int COLOR_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 9;

  // Register reset values and colour constants
  localparam logic [CFG_W-1:0]   PIX_DIM_RESET = 9'd256;
  localparam logic [COLOR_W-1:0] RED_565       = 16'hF800;
  localparam logic [7:0]         KEY_HIGH      = 8'd224;
  localparam logic [7:0]         KEY_LOW       = 8'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_KEYED = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_OOB     = 2'd1,
    ST_KEYED   = 2'd2,
    ST_CLIPPED = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROTATION = 2'd0,
    CFG_MIRROR   = 2'd1,
    CFG_WIDTH    = 2'd2,
    CFG_HEIGHT   = 2'd3
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic accept_en;
    logic map_en;
    logic addr_en;
    logic mem_en;
    logic clr_step;
    logic res_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_fire;
    logic is_clear;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/rfpa_if.sv @@
interface rfpa_req_if;
  import rfpa_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic [COLOR_W-1:0] color;

  modport source (output valid, mode, x_coord, y_coord, color, input ready);
  modport sink   (input valid, mode, x_coord, y_coord, color, output ready);
endinterface

interface rfpa_rsp_if;
  import rfpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  read_data;
  logic [STATUS_W-1:0] status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

interface rfpa_cfg_if;
  import rfpa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/rfpa_ctrl.sv @@
module rfpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  rfpa_pkg::sts_t sts,
  output rfpa_pkg::cmd_t cmd
);
  import rfpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_ADDR,
    S_MEM,
    S_CLEAR,
    S_RESULT
  } state_t;

  state_t state;

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:   if (sts.req_fire) state <= S_MAP;
        S_MAP:    state <= sts.is_clear ? S_CLEAR : S_ADDR;
        S_ADDR:   state <= S_MEM;
        S_MEM:    state <= S_RESULT;
        S_CLEAR:  if (sts.clr_last) state <= S_RESULT;
        S_RESULT: if (sts.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Decode commands from the state
  always_comb begin
    cmd           = '0;
    cmd.accept_en = (state == S_IDLE);
    cmd.map_en    = (state == S_MAP);
    cmd.addr_en   = (state == S_ADDR);
    cmd.mem_en    = (state == S_MEM);
    cmd.clr_step  = (state == S_CLEAR);
    cmd.res_load  = (state == S_RESULT) && sts.out_free;
  end

endmodule

@@ hdl/rfpa_dp.sv @@
module rfpa_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic           clk,
  input  logic           rst,
  rfpa_req_if.sink       req,
  rfpa_rsp_if.source     rsp,
  rfpa_cfg_if.sink       cfg,
  input  rfpa_pkg::cmd_t cmd,
  output rfpa_pkg::sts_t sts
);
  import rfpa_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DW    = (WW > HW) ? WW : HW;
  localparam int LW    = (DW > CFG_W) ? DW : CFG_W;
  localparam int CW    = ((DW > COORD_W + 1) ? DW : COORD_W + 1) + 2;
  localparam int PW    = YW + WW;
  localparam int QW    = WW + HW;

  // Configuration registers
  logic [1:0]       rotation;
  logic [1:0]       mirror_mode;
  logic [CFG_W-1:0] pix_width;
  logic [CFG_W-1:0] pix_height;

  // Item registers
  logic [MODE_W-1:0]  mode_q;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic [COLOR_W-1:0] color_q;

  // Mapping results
  logic [XW-1:0]       px_q;
  logic [YW-1:0]       py_q;
  logic                inb_q;
  logic                wr_ok;
  logic                rd_ok;
  logic [STATUS_W-1:0] status_q;
  logic [AW-1:0]       addr_q;
  logic [AW-1:0]       cnt;
  logic [AW-1:0]       area_m1;

  // Result register
  logic                out_valid;
  logic [COLOR_W-1:0]  out_data;
  logic [STATUS_W-1:0] out_status;

  // Store
  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata;

  logic [LW-1:0]      pw_ext;
  logic [LW-1:0]      ph_ext;
  logic [WW-1:0]      eff_w;
  logic [HW-1:0]      eff_h;
  logic signed [CW-1:0] w_s, h_s, x_s, y_s, px_c, py_c;
  logic               inb_c;
  logic               clip_c;
  logic               key_c;
  logic [LW-1:0]      lw;
  logic [LW-1:0]      lh;
  logic [PW-1:0]      addr_sum;
  logic [QW-1:0]      area;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic               req_fire;

  // Saturate the panel size into the store's range
  always_comb begin
    pw_ext = LW'(pix_width);
    ph_ext = LW'(pix_height);
    if (pw_ext == '0)                  eff_w = WW'(1);
    else if (pw_ext > LW'(MAX_WIDTH))  eff_w = WW'(MAX_WIDTH);
    else                               eff_w = WW'(pw_ext);
    if (ph_ext == '0)                  eff_h = HW'(1);
    else if (ph_ext > LW'(MAX_HEIGHT)) eff_h = HW'(MAX_HEIGHT);
    else                               eff_h = HW'(ph_ext);
  end

  // Rotate, then mirror, then bounds test
  always_comb begin
    w_s = $signed(CW'(eff_w));
    h_s = $signed(CW'(eff_h));
    x_s = $signed(CW'(x_q));
    y_s = $signed(CW'(y_q));
    case (rotation)
      2'd0: begin
        px_c = x_s;
        py_c = y_s;
      end
      2'd1: begin
        px_c = w_s - y_s - CW'(1);
        py_c = x_s;
      end
      2'd2: begin
        px_c = w_s - x_s - CW'(1);
        py_c = h_s - y_s - CW'(1);
      end
      default: begin
        px_c = y_s;
        py_c = h_s - x_s - CW'(1);
      end
    endcase
    if (mirror_mode[0]) px_c = w_s - px_c - CW'(1);
    if (mirror_mode[1]) py_c = h_s - py_c - CW'(1);
    inb_c = (px_c >= 0) && (px_c < w_s) && (py_c >= 0) && (py_c < h_s);
  end

  // Clip against the logical bounds and test the colour key
  always_comb begin
    lw     = rotation[0] ? LW'(eff_h) : LW'(eff_w);
    lh     = rotation[0] ? LW'(eff_w) : LW'(eff_h);
    clip_c = (mode_q == MODE_KEYED) && ((LW'(x_q) >= lw) || (LW'(y_q) >= lh));
    key_c  = (mode_q == MODE_KEYED)
             && ({color_q[15:11], 3'b000} >= KEY_HIGH)
             && ({color_q[10:5], 2'b00} <= KEY_LOW)
             && ({color_q[4:0], 3'b000} >= KEY_HIGH);
  end

  assign addr_sum = PW'(py_q) * PW'(eff_w) + PW'(px_q);
  assign area     = QW'(eff_w) * QW'(eff_h);

  // Take configuration writes
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation    <= '0;
      mirror_mode <= '0;
      pix_width   <= PIX_DIM_RESET;
      pix_height  <= PIX_DIM_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ROTATION: rotation    <= cfg.data[1:0];
        CFG_MIRROR:   mirror_mode <= cfg.data[1:0];
        CFG_WIDTH:    pix_width   <= cfg.data;
        CFG_HEIGHT:   pix_height  <= cfg.data;
        default:      rotation    <= rotation;
      endcase
    end
  end

  // Capture an item
  assign req.ready = cmd.accept_en && !rst;
  assign req_fire  = req.valid && cmd.accept_en && !rst;

  always_ff @(posedge clk) begin
    if (req_fire) begin
      mode_q  <= req.mode;
      x_q     <= req.x_coord;
      y_q     <= req.y_coord;
      color_q <= req.color;
    end
  end

  // Register the mapping, the decision and the status
  always_ff @(posedge clk) begin
    area_m1 <= AW'(area - QW'(1));
    if (cmd.map_en) begin
      px_q  <= px_c[XW-1:0];
      py_q  <= py_c[YW-1:0];
      inb_q <= inb_c;
      wr_ok <= ((mode_q == MODE_WRITE) || (mode_q == MODE_KEYED))
               && !clip_c && !key_c && inb_c;
      rd_ok <= (mode_q == MODE_READ) && inb_c;
      if (mode_q == MODE_CLEAR) status_q <= ST_DONE;
      else if (clip_c)          status_q <= ST_CLIPPED;
      else if (key_c)           status_q <= ST_KEYED;
      else if (!inb_c)          status_q <= ST_OOB;
      else                      status_q <= ST_DONE;
    end
    if (cmd.addr_en) addr_q <= AW'(addr_sum);
  end

  // Walk the active area for a clear
  always_ff @(posedge clk) begin
    if (cmd.map_en)        cnt <= '0;
    else if (cmd.clr_step) cnt <= cnt + AW'(1);
  end

  // Store: one write port, one registered read port
  assign mem_we    = (cmd.mem_en && wr_ok) || cmd.clr_step;
  assign mem_waddr = cmd.clr_step ? cnt : addr_q;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= color_q;
    if (cmd.mem_en && rd_ok) rdata <= mem[addr_q];
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status <= status_q;
      if (mode_q != MODE_READ) out_data <= '0;
      else if (inb_q)          out_data <= rdata;
      else                     out_data <= RED_565;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;
  assign rsp.status    = out_status;

  assign sts.req_fire = req_fire;
  assign sts.is_clear = (mode_q == MODE_CLEAR);
  assign sts.clr_last = (cnt == area_m1);
  assign sts.out_free = !out_valid || rsp.ready;

endmodule

@@ hdl/rotated_framebuffer_pixel_access.sv @@
// RGB565 framebuffer with rotated and mirrored pixel addressing.
// Channels: req carries one item (mode, x_coord, y_coord, color), rsp returns
// exactly one result per item (read_data, status), cfg writes the rotation,
// mirror_mode, pix_width and pix_height registers by index. All three use a
// valid/ready handshake; cfg is ready whenever out of reset. cfg must be
// written only while idle; the block itself does not enforce it. req and cfg
// are held not ready during reset. A pixel write or read passes through the
// map, address, store access and result steps after the item is taken; the
// block takes one item at a time and takes no new item until the last one's
// result is loaded. A clear writes one store entry per cycle over the active
// W*H area, then loads its result. The store has a single write port; the
// controller steps through its map, address and access sequence in turn.
// Reset loads the register defaults (no rotation, no mirror, 256 x 256) and
// empties the result register; the store itself is not cleared and must be
// filled by a clear before it is read.
// A finished result waits in the output register while the block goes back
// to take the next item; if rsp stalls, that next item waits at its result
// step and req.ready stays low until the held result is taken.
module rotated_framebuffer_pixel_access #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input logic        clk,
  input logic        rst,
  rfpa_req_if.sink   req,
  rfpa_rsp_if.source rsp,
  rfpa_cfg_if.sink   cfg
);
  import rfpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rfpa_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rfpa_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts)
  );

endmodule
